// File: sv/assert_macros.svh
// Assertion macros shared by the bank crossbar arbiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/bca_pkg.sv
// Shared helpers for the bank crossbar arbiter.
`default_nettype none

package bca_pkg;

  function automatic int unsigned idx_width(input int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

// File: sv/bca_arbiter.sv
// Bank and channel connection state with the fixed-priority select logic.
`default_nettype none

`include "assert_macros.svh"

module bca_arbiter
  import bca_pkg::*;
#(
  parameter int unsigned CHANNELS = 4,
  parameter int unsigned BANKS    = 4,
  localparam int unsigned BW = idx_width(BANKS),
  localparam int unsigned CW = idx_width(CHANNELS)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   advance_i,
  input  wire logic [CHANNELS-1:0]    read_requests_i,
  input  wire logic [CHANNELS-1:0]    write_requests_i,
  input  wire logic [CHANNELS*BW-1:0] bank_selects_i,
  input  wire logic [BANKS-1:0]       bank_acks_i,
  output logic      [BANKS-1:0]       bank_driven_o,
  output logic      [BANKS*CW-1:0]    bank_sources_o,
  output logic      [BANKS-1:0]       bank_reads_o,
  output logic      [BANKS-1:0]       bank_writes_o,
  output logic      [CHANNELS-1:0]    channel_linked_o,
  output logic      [CHANNELS*BW-1:0] channel_banks_o,
  output logic      [CHANNELS-1:0]    channel_acks_o
);

  logic [BANKS-1:0]    held_q, held_d;
  logic [CW-1:0]       owner_q [BANKS];
  logic [CW-1:0]       owner_d [BANKS];
  logic [CHANNELS-1:0] linked_q, linked_d;
  logic [BW-1:0]       cbank_q [CHANNELS];
  logic [BW-1:0]       cbank_d [CHANNELS];

  logic [CHANNELS-1:0] req;
  logic [BANKS-1:0]    found;
  logic [BANKS-1:0]    keep;
  logic [BANKS-1:0]    grab;
  logic [CW-1:0]       pick [BANKS];
  logic [CW-1:0]       src  [BANKS];

  assign req = read_requests_i | write_requests_i;

  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      found[b] = 1'b0;
      pick[b]  = '0;
      for (int c = CHANNELS - 1; c >= 0; c--) begin
        if (req[c] && (bank_selects_i[c*BW +: BW] == BW'(b))) begin
          found[b] = 1'b1;
          pick[b]  = CW'(c);
        end
      end
      keep[b]  = held_q[b] & ~bank_acks_i[b];
      grab[b]  = ~keep[b] & found[b];
      src[b]   = keep[b] ? owner_q[b] : pick[b];
      bank_driven_o[b]          = keep[b] | found[b];
      bank_sources_o[b*CW +: CW] = bank_driven_o[b] ? src[b] : '0;
      bank_reads_o[b]           = bank_driven_o[b] & read_requests_i[src[b]];
      bank_writes_o[b]          = bank_driven_o[b] & write_requests_i[src[b]];
      held_d[b]  = keep[b] | found[b];
      owner_d[b] = grab[b] ? pick[b] : owner_q[b];
    end
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      channel_linked_o[c]        = linked_q[c];
      channel_banks_o[c*BW +: BW] = linked_q[c] ? cbank_q[c] : '0;
      channel_acks_o[c]          = linked_q[c] & bank_acks_i[cbank_q[c]];
      linked_d[c] = linked_q[c];
      cbank_d[c]  = cbank_q[c];
      for (int b = 0; b < BANKS; b++) begin
        if (grab[b]) begin
          if (pick[b] == CW'(c)) begin
            linked_d[c] = 1'b1;
            cbank_d[c]  = BW'(b);
          end else if (cbank_q[c] == BW'(b)) begin
            linked_d[c] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      linked_q <= '0;
      for (int b = 0; b < BANKS; b++) begin
        owner_q[b] <= '0;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        cbank_q[c] <= '0;
      end
    end else if (advance_i) begin
      held_q   <= held_d;
      linked_q <= linked_d;
      owner_q  <= owner_d;
      cbank_q  <= cbank_d;
    end
  end

  `ASSERT_NXT(held_follows_drive, clk_i, rst_ni, advance_i, held_q == $past(bank_driven_o))
  `ASSERT_NXT(state_frozen_on_stall, clk_i, rst_ni, !advance_i,
              $stable(held_q) && $stable(linked_q))
  `ASSERT_IMP(linked_ack_needs_link, clk_i, rst_ni, 1'b1,
              (channel_acks_o & ~linked_q) == '0)

endmodule

`default_nettype wire

// File: sv/bank_crossbar_arbiter_unit.sv
// Top level of the bank crossbar arbiter: request register, arbiter and result register.
//
//   Channel   Dir  Payload (tdata, lowest bits first)
//   s_axis    in   read_requests, write_requests, bank_selects, bank_acks
//   m_axis    out  bank_driven, bank_sources, bank_reads, bank_writes,
//                  channel_linked, channel_banks, channel_acks
//
// A result is registered when its request moves from the request register into the
// result register, which a stall on the result side can hold off. One request is
// accepted per cycle while the result side keeps up.
// The connection state updates when a request moves from the request register into
// the result register, so results follow the order of accepted requests.
// Reset clears both valid flags and all connection state.
// A stalled result register holds its result, backing up into the request register.
`default_nettype none

`include "assert_macros.svh"

module bank_crossbar_arbiter_unit
  import bca_pkg::*;
#(
  parameter int unsigned CHANNELS = 4,
  parameter int unsigned BANKS    = 4,
  localparam int unsigned BW     = idx_width(BANKS),
  localparam int unsigned CW     = idx_width(CHANNELS),
  localparam int unsigned IN_W   = 2 * CHANNELS + CHANNELS * BW + BANKS,
  localparam int unsigned OUT_W  = 3 * BANKS + BANKS * CW + 2 * CHANNELS + CHANNELS * BW,
  localparam int unsigned IN_TW  = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // read_requests, write_requests, bank_selects, bank_acks
  input  wire logic [IN_TW-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  // bank_driven, bank_sources, bank_reads, bank_writes,
  // channel_linked, channel_banks, channel_acks
  output logic      [OUT_TW-1:0] m_axis_tdata_o
);

  logic             in_valid_q, in_valid_d;
  logic [IN_W-1:0]  in_q;
  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_q;
  logic             advance;
  logic             s_accept;
  logic [OUT_W-1:0] result;

  logic [BANKS-1:0]       bank_driven;
  logic [BANKS*CW-1:0]    bank_sources;
  logic [BANKS-1:0]       bank_reads;
  logic [BANKS-1:0]       bank_writes;
  logic [CHANNELS-1:0]    channel_linked;
  logic [CHANNELS*BW-1:0] channel_banks;
  logic [CHANNELS-1:0]    channel_acks;

  assign advance         = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;
  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;
  assign in_valid_d      = s_accept | (in_valid_q & ~advance);
  assign out_valid_d     = advance | (out_valid_q & ~m_axis_tready_i);

  bca_arbiter #(
    .CHANNELS(CHANNELS),
    .BANKS   (BANKS)
  ) u_arbiter (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .read_requests_i  (in_q[CHANNELS-1:0]),
    .write_requests_i (in_q[CHANNELS +: CHANNELS]),
    .bank_selects_i   (in_q[2*CHANNELS +: CHANNELS*BW]),
    .bank_acks_i      (in_q[2*CHANNELS + CHANNELS*BW +: BANKS]),
    .bank_driven_o    (bank_driven),
    .bank_sources_o   (bank_sources),
    .bank_reads_o     (bank_reads),
    .bank_writes_o    (bank_writes),
    .channel_linked_o (channel_linked),
    .channel_banks_o  (channel_banks),
    .channel_acks_o   (channel_acks)
  );

  assign result = {channel_acks, channel_banks, channel_linked,
                   bank_writes, bank_reads, bank_sources, bank_driven};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_q <= s_axis_tdata_i[IN_W-1:0];
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TW'(out_q);

  `ASSERT_IMP(result_from_request, clk_i, rst_ni, $rose(out_valid_q), $past(in_valid_q))
  `ASSERT_NXT(stalled_request_kept, clk_i, rst_ni, in_valid_q && !advance, in_valid_q)
  `ASSERT_IMP(ready_when_empty, clk_i, rst_ni, !in_valid_q, s_axis_tready_o)

endmodule

`default_nettype wire
